[sv/pps_pkg.sv]
// Shared types, constants and controller/datapath command encoding for the
// pure pursuit steering block. No dependencies.
`timescale 1ns / 1ps

package pps_pkg;

	// Waypoint table geometry
	localparam int MAX_WAYPOINTS = 1024;
	localparam int WP_AW         = $clog2(MAX_WAYPOINTS);
	localparam int WP_CW         = $clog2(MAX_WAYPOINTS + 1);
	localparam int IDX_W         = 10;

	// Operation codes of an input beat
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Configuration register indexes
	localparam logic [1:0] CFG_LOOKAHEAD = 2'd0;
	localparam logic [1:0] CFG_SPEED     = 2'd1;
	localparam logic [1:0] CFG_LIMIT     = 2'd2;
	localparam logic [1:0] CFG_GAIN      = 2'd3;

	// Configuration reset values
	localparam logic [30:0] LOOKAHEAD_RST = 31'd98304;
	localparam logic [15:0] SPEED_RST     = 16'd256;
	localparam logic [14:0] LIMIT_RST     = 15'd4096;
	localparam logic [15:0] GAIN_RST      = 16'd16384;

	typedef struct packed {
		logic               operation;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] shift_x;
		logic signed [31:0] shift_y;
		logic signed [15:0] yaw_cos;
		logic signed [15:0] yaw_sin;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] steer_angle;
		logic [15:0]        drive_speed;
		logic               pair_found;
		logic [IDX_W-1:0]   target_index;
	} out_item_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_RD,
		ST_MUL,
		ST_SUM,
		ST_SQ,
		ST_TEST,
		ST_SINIT,
		ST_SMUL,
		ST_SADD,
		ST_SSQ,
		ST_SCMP,
		ST_GMUL,
		ST_D1CHK,
		ST_D1STEP,
		ST_MAG,
		ST_D2INIT,
		ST_D2STEP,
		ST_DONE
	} st_t;

	typedef enum logic [4:0] {
		DP_NOP,
		DP_WRITE,
		DP_POSE,
		DP_READ,
		DP_XMUL,
		DP_XSUM,
		DP_SQ,
		DP_SHIFT,
		DP_SINIT,
		DP_SMUL,
		DP_SADD,
		DP_SSQ,
		DP_SCMP,
		DP_GMUL,
		DP_D1CHK,
		DP_D1STEP,
		DP_MAG,
		DP_D2INIT,
		DP_D2STEP,
		DP_RESULT
	} dp_op_t;

	typedef struct packed {
		dp_op_t           op;
		logic [WP_AW-1:0] addr;
		logic [4:0]       bit_sel;
		logic             res_found;
		logic [IDX_W-1:0] res_idx;
		logic             res_empty;
	} dp_cmd_t;

	typedef struct packed {
		logic hit;
		logic d1_direct;
	} dp_sts_t;

endpackage

[sv/pure_pursuit_steering.sv]
// Top level of the pure pursuit steering block: joins controller and
// datapath. Depends on pps_pkg, pps_ctrl and pps_dpath.
//
//  channel | signals                              | beat when
//  --------+--------------------------------------+------------------------
//  input   | in_valid, in_ready, in_data          | in_valid && in_ready
//  output  | out_valid, out_ready, out_data       | out_valid && out_ready
//  config  | cfg_write, cfg_index, cfg_data       | cfg_write
//
// A load beat is written into the table from the idle state. A tick walks
// the pairs, each waypoint passing through the single memory read port,
// transform multipliers, summing, squarer and circle test, then runs 31 search
// steps (multiply, add, square, compare) and two restoring dividers (15 and
// 17 steps). When the steering clamps at once, or the squared lookahead is
// zero, the first divider is skipped. An empty table skips the walk and
// answers a tick with a zero result. After reset the table is empty and no
// clearing pass is run. A held result stalls only the next tick at its end; loads and ticks are taken while it waits.
`timescale 1ns / 1ps

module pure_pursuit_steering import pps_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [30:0] cfg_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Sequencing
	pps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_op     (in_data.operation),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Arithmetic and storage
	pps_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.result    (out_data)
	);

endmodule

[sv/pps_dpath.sv]
// Datapath of the pure pursuit steering block: waypoint memory, frame
// transform, circle tests, segment search and the two dividers.
// Depends on pps_pkg; driven by pps_ctrl through dp_cmd_t.
`timescale 1ns / 1ps

module pps_dpath import pps_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [30:0] cfg_data,
	input  in_item_t    in_data,
	input  dp_cmd_t     cmd,
	output dp_sts_t     sts,
	output out_item_t   result
);

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		logic signed [31:0] r;
		if (v > 36'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -36'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// Configuration registers
	logic [30:0] la_q;
	logic [15:0] spd_q;
	logic [14:0] lim_q;
	logic [15:0] gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			la_q   <= LOOKAHEAD_RST;
			spd_q  <= SPEED_RST;
			lim_q  <= LIMIT_RST;
			gain_q <= GAIN_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_LOOKAHEAD: la_q   <= cfg_data;
				CFG_SPEED:     spd_q  <= cfg_data[15:0];
				CFG_LIMIT:     lim_q  <= cfg_data[14:0];
				CFG_GAIN:      gain_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Waypoint memory, {x, y} per entry
	logic [63:0] wp_mem [MAX_WAYPOINTS];
	logic [63:0] rd_q;

	always_ff @(posedge clk) begin
		if (cmd.op == DP_WRITE) begin
			wp_mem[cmd.addr] <= {in_data.point_x, in_data.point_y};
		end
		if (cmd.op == DP_READ) begin
			rd_q <= wp_mem[cmd.addr];
		end
	end

	// Payload registers
	logic signed [15:0] c_q, s_q;
	logic signed [31:0] tx_q, ty_q;
	logic [61:0]        l2_q;
	logic signed [47:0] pcx_q, psy_q, psx_q, pcy_q;
	logic signed [31:0] x2_q, y2_q, x1_q, y1_q;
	logic [62:0]        sqx_q, sqy_q;
	logic [63:0]        n1_q;
	logic signed [32:0] dx_q, dy_q;
	logic [30:0]        t_q;
	logic signed [31:0] yh_q, px_q, py_q;
	logic signed [63:0] mx_q, my_q;
	logic [47:0]        num_q;
	logic [14:0]        mag_q;
	logic [60:0]        rem1_q;
	logic [14:0]        q1_q;
	logic [17:0]        den_q;
	logic [29:0]        rem2_q;
	logic [16:0]        q2_q;
	out_item_t          res_q;

	// Combinational helpers
	logic signed [31:0] rx, ry;
	logic signed [47:0] pcx_w, psy_w, psx_w, pcy_w;
	logic signed [48:0] xs_raw, ys_raw;
	logic signed [35:0] xs_sh, ys_sh;
	logic signed [63:0] sqa_w, sqb_w;
	logic signed [31:0] sqa_in, sqb_in;
	logic [63:0]        n2, l2_ext;
	logic [30:0]        cand;
	logic signed [63:0] mx_w, my_w;
	logic signed [33:0] px_w, py_w;
	logic [31:0]        ay;
	logic [47:0]        num_w;
	logic [76:0]        dv1;
	logic [34:0]        dv2;
	logic [61:0]        la2_w;

	always_comb begin
		rx     = signed'(rd_q[63:32]);
		ry     = signed'(rd_q[31:0]);
		pcx_w  = c_q * rx;
		psy_w  = s_q * ry;
		psx_w  = s_q * rx;
		pcy_w  = c_q * ry;
		xs_raw = 49'(pcx_q) - 49'(psy_q) + 49'sd8192;
		ys_raw = 49'(psx_q) + 49'(pcy_q) + 49'sd8192;
		xs_sh  = 36'(xs_raw >>> 14) + 36'(tx_q);
		ys_sh  = 36'(ys_raw >>> 14) + 36'(ty_q);
		sqa_in = (cmd.op == DP_SSQ) ? px_q : x2_q;
		sqb_in = (cmd.op == DP_SSQ) ? py_q : y2_q;
		sqa_w  = sqa_in * sqa_in;
		sqb_w  = sqb_in * sqb_in;
		n2     = {1'b0, sqx_q} + {1'b0, sqy_q};
		l2_ext = {2'b00, l2_q};
		cand   = t_q | (31'd1 << cmd.bit_sel);
		mx_w   = dx_q * signed'({1'b0, cand});
		my_w   = dy_q * signed'({1'b0, cand});
		px_w   = 34'(x1_q) + 34'(mx_q >>> 30);
		py_w   = 34'(y1_q) + 34'(my_q >>> 30);
		ay     = yh_q[31] ? (~yh_q + 32'd1) : yh_q;
		num_w  = gain_q * ay;
		dv1    = 77'(l2_q) << cmd.bit_sel;
		dv2    = 35'(den_q) << cmd.bit_sel;
		la2_w  = la_q * la_q;
	end

	// Status back to the controller
	always_comb begin
		sts.hit = (n1_q <= l2_ext) && (n2 > l2_ext) && (x1_q > 0) && (x2_q > 0);
		sts.d1_direct = (l2_q == '0) || ({16'd0, num_q[47:2]} >= l2_q);
	end

	// Datapath register updates
	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_POSE: begin
				c_q  <= in_data.yaw_cos;
				s_q  <= in_data.yaw_sin;
				tx_q <= in_data.shift_x;
				ty_q <= in_data.shift_y;
				l2_q <= la2_w;
			end
			DP_XMUL: begin
				pcx_q <= pcx_w;
				psy_q <= psy_w;
				psx_q <= psx_w;
				pcy_q <= pcy_w;
			end
			DP_XSUM: begin
				x2_q <= sat32(xs_sh);
				y2_q <= sat32(ys_sh);
			end
			DP_SQ, DP_SSQ: begin
				sqx_q <= sqa_w[62:0];
				sqy_q <= sqb_w[62:0];
			end
			DP_SHIFT: begin
				x1_q <= x2_q;
				y1_q <= y2_q;
				n1_q <= n2;
			end
			DP_SINIT: begin
				dx_q <= 33'(x2_q) - 33'(x1_q);
				dy_q <= 33'(y2_q) - 33'(y1_q);
				t_q  <= '0;
				yh_q <= y1_q;
			end
			DP_SMUL: begin
				mx_q <= mx_w;
				my_q <= my_w;
			end
			DP_SADD: begin
				px_q <= px_w[31:0];
				py_q <= py_w[31:0];
			end
			DP_SCMP: begin
				// keep the candidate while the point stays inside; stop at t = 1.0
				if ((n2 <= l2_ext) && !t_q[30]) begin
					t_q  <= cand;
					yh_q <= py_q;
				end
			end
			DP_GMUL: begin
				num_q <= num_w;
			end
			DP_D1CHK: begin
				if (l2_q == '0) begin
					mag_q <= (num_q != '0) ? lim_q : '0;
				end else begin
					mag_q <= lim_q;
				end
				rem1_q <= {num_q, 13'd0};
				q1_q   <= '0;
			end
			DP_D1STEP: begin
				if ({16'd0, rem1_q} >= dv1) begin
					rem1_q <= rem1_q - dv1[60:0];
					q1_q   <= q1_q | (15'd1 << cmd.bit_sel);
				end
			end
			DP_MAG: begin
				mag_q <= (q1_q > lim_q) ? lim_q : q1_q;
			end
			DP_D2INIT: begin
				den_q  <= 18'd12288 + 18'(mag_q) + (18'(mag_q) << 2);
				rem2_q <= {spd_q, 14'd0};
				q2_q   <= '0;
			end
			DP_D2STEP: begin
				if ({5'd0, rem2_q} >= dv2) begin
					rem2_q <= rem2_q - dv2[29:0];
					q2_q   <= q2_q | (17'd1 << cmd.bit_sel);
				end
			end
			DP_RESULT: begin
				if (cmd.res_empty) begin
					res_q <= '0;
				end else begin
					res_q.steer_angle  <= yh_q[31] ? -signed'(16'(mag_q)) : signed'(16'(mag_q));
					res_q.drive_speed  <= q2_q[16] ? 16'hFFFF : q2_q[15:0];
					res_q.pair_found   <= cmd.res_found;
					res_q.target_index <= cmd.res_idx;
				end
			end
			default: ;
		endcase
	end

	assign result = res_q;

endmodule

[sv/pps_ctrl.sv]
// Controller of the pure pursuit steering block: handshakes, waypoint count,
// pair walk, search and divider sequencing. Depends on pps_pkg.
`timescale 1ns / 1ps

module pps_ctrl import pps_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic     in_op,
	output logic     out_valid,
	input  logic     out_ready,
	output dp_cmd_t  cmd,
	input  dp_sts_t  sts
);

	st_t               state_q, state_nx;
	logic [WP_CW-1:0]  cnt_q, k_q;
	logic [WP_AW-1:0]  i_q, last_idx_q, nxt_i, start_i;
	logic              last_vld_q, first_q, found_q, empty_q, out_valid_q;
	logic [4:0]        bit_q;
	logic              in_acc, out_free, pairs_done;
	logic [IDX_W+WP_AW-1:0] idx_ext;

	always_comb begin
		in_acc     = in_valid && (state_q == ST_IDLE);
		out_free   = !out_valid_q || out_ready;
		nxt_i      = ((WP_CW'(i_q) + 1'b1) >= cnt_q) ? '0 : i_q + 1'b1;
		start_i    = (last_vld_q && (WP_CW'(last_idx_q) < cnt_q)) ? last_idx_q : '0;
		pairs_done = (k_q + 1'b1) == cnt_q;
		idx_ext    = {{IDX_W{1'b0}}, i_q};
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && (in_op == OP_TICK)) begin
					state_nx = (cnt_q == '0) ? ST_DONE : ST_RD;
				end
			end
			ST_RD:     state_nx = ST_MUL;
			ST_MUL:    state_nx = ST_SUM;
			ST_SUM:    state_nx = ST_SQ;
			ST_SQ:     state_nx = ST_TEST;
			ST_TEST: begin
				if (first_q) begin
					state_nx = ST_RD;
				end else if (sts.hit || pairs_done) begin
					state_nx = ST_SINIT;
				end else begin
					state_nx = ST_RD;
				end
			end
			ST_SINIT:  state_nx = ST_SMUL;
			ST_SMUL:   state_nx = ST_SADD;
			ST_SADD:   state_nx = ST_SSQ;
			ST_SSQ:    state_nx = ST_SCMP;
			ST_SCMP:   state_nx = (bit_q == '0) ? ST_GMUL : ST_SMUL;
			ST_GMUL:   state_nx = ST_D1CHK;
			ST_D1CHK:  state_nx = sts.d1_direct ? ST_D2INIT : ST_D1STEP;
			ST_D1STEP: state_nx = (bit_q == '0) ? ST_MAG : ST_D1STEP;
			ST_MAG:    state_nx = ST_D2INIT;
			ST_D2INIT: state_nx = ST_D2STEP;
			ST_D2STEP: state_nx = (bit_q == '0) ? ST_DONE : ST_D2STEP;
			ST_DONE:   state_nx = out_free ? ST_IDLE : ST_DONE;
			default:   state_nx = ST_IDLE;
		endcase
	end

	// Outputs and datapath commands
	always_comb begin
		in_ready      = (state_q == ST_IDLE);
		out_valid     = out_valid_q;
		cmd           = '0;
		cmd.op        = DP_NOP;
		cmd.bit_sel   = bit_q;
		cmd.addr      = first_q ? i_q : nxt_i;
		cmd.res_found = found_q;
		cmd.res_idx   = idx_ext[IDX_W-1:0];
		cmd.res_empty = empty_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && (in_op == OP_LOAD) && (cnt_q < WP_CW'(MAX_WAYPOINTS))) begin
					cmd.op   = DP_WRITE;
					cmd.addr = cnt_q[WP_AW-1:0];
				end else if (in_acc && (in_op == OP_TICK) && (cnt_q != '0)) begin
					cmd.op = DP_POSE;
				end
			end
			ST_RD:     cmd.op = DP_READ;
			ST_MUL:    cmd.op = DP_XMUL;
			ST_SUM:    cmd.op = DP_XSUM;
			ST_SQ:     cmd.op = DP_SQ;
			ST_TEST: begin
				if (first_q || !(sts.hit || pairs_done)) begin
					cmd.op = DP_SHIFT;
				end
			end
			ST_SINIT:  cmd.op = DP_SINIT;
			ST_SMUL:   cmd.op = DP_SMUL;
			ST_SADD:   cmd.op = DP_SADD;
			ST_SSQ:    cmd.op = DP_SSQ;
			ST_SCMP:   cmd.op = DP_SCMP;
			ST_GMUL:   cmd.op = DP_GMUL;
			ST_D1CHK:  cmd.op = DP_D1CHK;
			ST_D1STEP: cmd.op = DP_D1STEP;
			ST_MAG:    cmd.op = DP_MAG;
			ST_D2INIT: cmd.op = DP_D2INIT;
			ST_D2STEP: cmd.op = DP_D2STEP;
			ST_DONE: begin
				if (out_free) begin
					cmd.op = DP_RESULT;
				end
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			k_q         <= '0;
			i_q         <= '0;
			last_idx_q  <= '0;
			last_vld_q  <= 1'b0;
			first_q     <= 1'b0;
			found_q     <= 1'b0;
			empty_q     <= 1'b0;
			bit_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			// hold result until taken, load a new one when free
			if (cmd.op == DP_RESULT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.op == DP_WRITE) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (in_acc && (in_op == OP_TICK)) begin
						empty_q <= (cnt_q == '0);
						found_q <= 1'b0;
						first_q <= 1'b1;
						k_q     <= '0;
						i_q     <= start_i;
					end
				end
				ST_TEST: begin
					if (first_q) begin
						first_q <= 1'b0;
					end else if (sts.hit) begin
						found_q    <= 1'b1;
						last_idx_q <= i_q;
						last_vld_q <= 1'b1;
					end else if (!pairs_done) begin
						i_q <= nxt_i;
						k_q <= k_q + 1'b1;
					end
					bit_q <= 5'd30;
				end
				ST_SCMP, ST_D1STEP, ST_D2STEP: begin
					if (bit_q != '0) begin
						bit_q <= bit_q - 1'b1;
					end
				end
				ST_D1CHK:  bit_q <= 5'd14;
				ST_D2INIT: bit_q <= 5'd16;
				default: ;
			endcase
		end
	end

	// Checks on the controller
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= WP_CW'(MAX_WAYPOINTS))
		else $error("waypoint count beyond table size");

	a_last_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		last_vld_q |-> (WP_CW'(last_idx_q) < cnt_q))
		else $error("remembered pair index outside the table");

	a_walk_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TEST) |-> ((WP_CW'(i_q) < cnt_q) && (k_q < cnt_q)))
		else $error("walk index or pair counter out of range");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> (cmd.op != DP_RESULT))
		else $error("pending result overwritten");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == DP_RESULT) |=> out_valid_q)
		else $error("loaded result not presented");

endmodule
